// File: rtl/jste_pkg.sv
package jste_pkg;

  localparam int MAX_JOBS  = 32;
  localparam int IDX_W     = $clog2(MAX_JOBS);
  localparam int CNT_W     = $clog2(MAX_JOBS + 1);
  localparam int ARR_W     = 16;
  localparam int BUR_W     = 16;
  localparam int TIME_W    = 22;
  localparam int JOB_IDX_W = 5;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  typedef struct packed {
    logic [ARR_W-1:0] arrival_time;
    logic [BUR_W-1:0] burst_time;
    logic             last_job;
  } in_item_t;

  typedef struct packed {
    logic [JOB_IDX_W-1:0] job_index;
    logic [TIME_W-1:0]    start_time;
    logic [TIME_W-1:0]    waiting_time;
    logic [TIME_W-1:0]    turnaround_time;
    logic                 last_result;
  } out_item_t;

  // command handed from front to back
  typedef struct packed {
    logic [ARR_W-1:0] arrival;
    logic [BUR_W-1:0] burst;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] count;
    logic             store;
    logic             last;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_START,
    BK_EMIT
  } bk_state_t;

endpackage

// File: rtl/job_schedule_timing_engine.sv
// Loading: one job per cycle is taken while the 4-entry command queue has room.
// A job without last_job gives no result. A set of n jobs gives n results (at most 32), one per
// scan of the job table (table reads and compares, then pick, then emit of the result).
// A waiting result holds the back end; the loader runs on until the command queue fills.
// Reset clears control state and sets policy to FCFS; the job table is not cleared.
module job_schedule_timing_engine
  import jste_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  cmd_t fq_data;
  cmd_t bq_data;
  logic fq_push;
  logic cq_full;
  logic cq_pop;
  logic cq_empty;

  jste_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .cq_full (cq_full),
    .in_full (in_full),
    .cq_push (fq_push),
    .cq_data (fq_data)
  );

  jste_cmd_q u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_data (fq_data),
    .full      (cq_full),
    .pop       (cq_pop),
    .pop_data  (bq_data),
    .empty     (cq_empty)
  );

  jste_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cq_data   (bq_data),
    .cq_empty  (cq_empty),
    .cq_pop    (cq_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

// File: rtl/jste_front.sv
module jste_front
  import jste_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_item_t in_data,
  input  logic     cq_full,
  output logic     in_full,
  output logic     cq_push,
  output cmd_t     cq_data
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  logic             room;

  assign in_full = cq_full;
  assign accept  = in_push && !cq_full;
  assign room    = (cnt_r < CNT_W'(MAX_JOBS));

  always_comb begin
    cq_data.arrival = in_data.arrival_time;
    cq_data.burst   = in_data.burst_time;
    cq_data.slot    = cnt_r[IDX_W-1:0];
    cq_data.store   = room;
    cq_data.last    = in_data.last_job;
    cq_data.count   = room ? cnt_r + CNT_W'(1) : cnt_r;
  end

  // a dropped job without last_job leaves nothing for the back end
  assign cq_push = accept && (room || in_data.last_job);

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_data.last_job) begin
        cnt_nxt = '0;
      end else if (room) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/jste_cmd_q.sv
module jste_cmd_q
  import jste_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t                slots_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CQ_CNT_W-1:0] cnt_r;
  logic                do_push, do_pop;

  assign full     = (cnt_r == CQ_CNT_W'(CQ_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_r + CQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_r + CQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CQ_CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/jste_back.sv
module jste_back
  import jste_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  cmd_t      cq_data,
  input  logic      cq_empty,
  output logic      cq_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_data
);

  bk_state_t state_r, state_nxt;

  logic [ARR_W-1:0] arr_mem [MAX_JOBS];
  logic [BUR_W-1:0] bur_mem [MAX_JOBS];
  logic [ARR_W-1:0] rd_arr_r;
  logic [BUR_W-1:0] rd_bur_r;
  logic [IDX_W-1:0] rd_addr;

  logic              policy_r;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic [MAX_JOBS-1:0] done_r, done_nxt;
  logic [TIME_W-1:0] clock_r, clock_nxt;

  logic              sjf_fnd_r, sjf_fnd_nxt;
  logic [IDX_W-1:0]  sjf_idx_r, sjf_idx_nxt;
  logic [ARR_W-1:0]  sjf_arr_r, sjf_arr_nxt;
  logic [BUR_W-1:0]  sjf_bur_r, sjf_bur_nxt;
  logic              fc_fnd_r, fc_fnd_nxt;
  logic [IDX_W-1:0]  fc_idx_r, fc_idx_nxt;
  logic [ARR_W-1:0]  fc_arr_r, fc_arr_nxt;
  logic [BUR_W-1:0]  fc_bur_r, fc_bur_nxt;

  logic [IDX_W-1:0]  pick_idx_r, pick_idx_nxt;
  logic [ARR_W-1:0]  pick_arr_r, pick_arr_nxt;
  logic [BUR_W-1:0]  pick_bur_r, pick_bur_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;

  logic              res_vld_r, res_vld_nxt;
  out_item_t         res_r, res_nxt;

  logic              mem_we;
  logic              issuing;
  logic              cand;
  logic              arrived;
  logic              sjf_better, fc_better;
  logic              use_sjf;
  logic [TIME_W-1:0] arr_ext;
  logic [TIME_W-1:0] wait_t;
  logic [TIME_W:0]   turn_sum, clk_sum;
  logic              res_free;
  logic              last_pick;

  assign out_empty = !res_vld_r;
  assign out_data  = res_r;

  assign issuing = (state_r == BK_SCAN) && (iss_r < n_r);
  assign rd_addr = issuing ? iss_r[IDX_W-1:0] : '0;
  assign mem_we  = (state_r == BK_IDLE) && !cq_empty && cq_data.store;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      arr_mem[cq_data.slot] <= cq_data.arrival;
      bur_mem[cq_data.slot] <= cq_data.burst;
    end
    rd_arr_r <= arr_mem[rd_addr];
    rd_bur_r <= bur_mem[rd_addr];
  end

  // compare of the job read last cycle against both running bests
  assign cand    = cmp_vld_r && !done_r[cmp_idx_r];
  assign arrived = ({{(TIME_W-ARR_W){1'b0}}, rd_arr_r} <= clock_r);
  assign sjf_better = !sjf_fnd_r || (rd_bur_r < sjf_bur_r) ||
                      ((rd_bur_r == sjf_bur_r) && (rd_arr_r < sjf_arr_r));
  assign fc_better  = !fc_fnd_r || (rd_arr_r < fc_arr_r) ||
                      ((rd_arr_r == fc_arr_r) && (rd_bur_r < fc_bur_r));
  assign use_sjf    = policy_r && sjf_fnd_r;

  assign arr_ext   = {{(TIME_W-ARR_W){1'b0}}, pick_arr_r};
  assign wait_t    = start_r - arr_ext;
  assign turn_sum  = {1'b0, wait_t} + {{(TIME_W+1-BUR_W){1'b0}}, pick_bur_r};
  assign clk_sum   = {1'b0, start_r} + {{(TIME_W+1-BUR_W){1'b0}}, pick_bur_r};
  assign res_free  = !res_vld_r || out_pop;
  assign last_pick = ((k_r + CNT_W'(1)) == n_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!cq_empty && cq_data.last) begin
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if ((iss_r == n_r) && !cmp_vld_r) begin
          state_nxt = BK_START;
        end
      end
      BK_START: begin
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (res_free) begin
          state_nxt = last_pick ? BK_IDLE : BK_SCAN;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    cq_pop       = 1'b0;
    n_nxt        = n_r;
    k_nxt        = k_r;
    iss_nxt      = iss_r;
    cmp_vld_nxt  = issuing;
    done_nxt     = done_r;
    clock_nxt    = clock_r;
    sjf_fnd_nxt  = sjf_fnd_r;
    sjf_idx_nxt  = sjf_idx_r;
    sjf_arr_nxt  = sjf_arr_r;
    sjf_bur_nxt  = sjf_bur_r;
    fc_fnd_nxt   = fc_fnd_r;
    fc_idx_nxt   = fc_idx_r;
    fc_arr_nxt   = fc_arr_r;
    fc_bur_nxt   = fc_bur_r;
    pick_idx_nxt = pick_idx_r;
    pick_arr_nxt = pick_arr_r;
    pick_bur_nxt = pick_bur_r;
    start_nxt    = start_r;
    res_vld_nxt  = res_vld_r && !out_pop;
    res_nxt      = res_r;
    case (state_r)
      BK_IDLE: begin
        cq_pop = !cq_empty;
        if (!cq_empty && cq_data.last) begin
          n_nxt      = cq_data.count;
          k_nxt      = '0;
          iss_nxt    = '0;
          clock_nxt  = '0;
          sjf_fnd_nxt = 1'b0;
          fc_fnd_nxt  = 1'b0;
        end
      end
      BK_SCAN: begin
        if (issuing) begin
          iss_nxt = iss_r + CNT_W'(1);
        end
        if (cand && arrived && sjf_better) begin
          sjf_fnd_nxt = 1'b1;
          sjf_idx_nxt = cmp_idx_r;
          sjf_arr_nxt = rd_arr_r;
          sjf_bur_nxt = rd_bur_r;
        end
        if (cand && fc_better) begin
          fc_fnd_nxt = 1'b1;
          fc_idx_nxt = cmp_idx_r;
          fc_arr_nxt = rd_arr_r;
          fc_bur_nxt = rd_bur_r;
        end
      end
      BK_START: begin
        pick_idx_nxt = use_sjf ? sjf_idx_r : fc_idx_r;
        pick_arr_nxt = use_sjf ? sjf_arr_r : fc_arr_r;
        pick_bur_nxt = use_sjf ? sjf_bur_r : fc_bur_r;
        // idle server: clock jumps ahead to the arrival
        if ({{(TIME_W-ARR_W){1'b0}}, pick_arr_nxt} > clock_r) begin
          start_nxt = {{(TIME_W-ARR_W){1'b0}}, pick_arr_nxt};
        end else begin
          start_nxt = clock_r;
        end
      end
      BK_EMIT: begin
        if (res_free) begin
          res_vld_nxt             = 1'b1;
          res_nxt.job_index       = JOB_IDX_W'(pick_idx_r);
          res_nxt.start_time      = start_r;
          res_nxt.waiting_time    = wait_t;
          res_nxt.turnaround_time = turn_sum[TIME_W] ? TIME_MAX : turn_sum[TIME_W-1:0];
          res_nxt.last_result     = last_pick;
          sjf_fnd_nxt             = 1'b0;
          fc_fnd_nxt              = 1'b0;
          iss_nxt                 = '0;
          if (last_pick) begin
            done_nxt  = '0;
            clock_nxt = '0;
          end else begin
            done_nxt[pick_idx_r] = 1'b1;
            clock_nxt = clk_sum[TIME_W] ? TIME_MAX : clk_sum[TIME_W-1:0];
            k_nxt     = k_r + CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      policy_r  <= 1'b0;
      n_r       <= '0;
      k_r       <= '0;
      iss_r     <= '0;
      cmp_vld_r <= 1'b0;
      done_r    <= '0;
      clock_r   <= '0;
      sjf_fnd_r <= 1'b0;
      fc_fnd_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      if (cfg_we) begin
        policy_r <= cfg_wdata;
      end
      n_r       <= n_nxt;
      k_r       <= k_nxt;
      iss_r     <= iss_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      done_r    <= done_nxt;
      clock_r   <= clock_nxt;
      sjf_fnd_r <= sjf_fnd_nxt;
      fc_fnd_r  <= fc_fnd_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r  <= rd_addr;
    sjf_idx_r  <= sjf_idx_nxt;
    sjf_arr_r  <= sjf_arr_nxt;
    sjf_bur_r  <= sjf_bur_nxt;
    fc_idx_r   <= fc_idx_nxt;
    fc_arr_r   <= fc_arr_nxt;
    fc_bur_r   <= fc_bur_nxt;
    pick_idx_r <= pick_idx_nxt;
    pick_arr_r <= pick_arr_nxt;
    pick_bur_r <= pick_bur_nxt;
    start_r    <= start_nxt;
    res_r      <= res_nxt;
  end

endmodule

// File: rtl/jste_checker.sv
module jste_checker
  import jste_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_full,
  input logic      out_pop,
  input logic      out_empty,
  input out_item_t out_data
);

  // no transaction survives reset on the result side
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result present after reset");

  a_rst_ready: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("stalled result changed");

  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !$isunknown(out_data))
    else $error("result fields unknown");

endmodule

bind job_schedule_timing_engine jste_checker u_chk (.*);

// File: dv/job_schedule_timing_engine_tb.sv
`timescale 1ns / 100ps

module job_schedule_timing_engine_tb;
  import jste_pkg::*;

  localparam logic POL_FCFS = 1'b0;
  localparam logic POL_SJF  = 1'b1;

  typedef enum int {
    MIX_CLUSTER,
    MIX_WIDE,
    MIX_SPREAD,
    MIX_CORNER
  } mix_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_push   = 1'b0;
  logic      in_full;
  in_item_t  in_data   = '0;
  logic      out_pop   = 1'b0;
  logic      out_empty;
  out_item_t out_data;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;

  in_item_t         job_feed_q[$];
  out_item_t        run_order_q[$];
  logic [ARR_W-1:0] arr_tab[MAX_JOBS];
  logic [BUR_W-1:0] bur_tab[MAX_JOBS];
  int               loaded_cnt     = 0;
  logic             policy_sh      = POL_FCFS;
  int               send_idle_pct  = 0;
  int               recv_stall_pct = 0;
  int               err_cnt        = 0;

  job_schedule_timing_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [TIME_W-1:0] sat_time(input int unsigned v);
    return (v > TIME_MAX) ? TIME_MAX : v[TIME_W-1:0];
  endfunction

  // Load one job; on last_job play out the whole set and queue the run order
  task automatic schedule_job(input in_item_t it);
    logic        done_f[MAX_JOBS];
    int unsigned tick;
    int unsigned wait_t;
    int          best;
    int          n;
    out_item_t   res;
    if (loaded_cnt < MAX_JOBS) begin
      arr_tab[loaded_cnt] = it.arrival_time;
      bur_tab[loaded_cnt] = it.burst_time;
      loaded_cnt++;
    end
    if (!it.last_job) return;
    n    = loaded_cnt;
    tick = 0;
    foreach (done_f[i]) done_f[i] = 1'b0;
    for (int k = 0; k < n; k++) begin
      best = -1;
      if (policy_sh == POL_SJF) begin
        for (int i = 0; i < n; i++) begin
          if (!done_f[i] && arr_tab[i] <= tick &&
              (best < 0 || {bur_tab[i], arr_tab[i]} < {bur_tab[best], arr_tab[best]}))
            best = i;
        end
      end
      // FCFS order, also the jump target when nothing has arrived under SJF
      if (best < 0) begin
        for (int i = 0; i < n; i++) begin
          if (!done_f[i] &&
              (best < 0 || {arr_tab[i], bur_tab[i]} < {arr_tab[best], bur_tab[best]}))
            best = i;
        end
      end
      if (arr_tab[best] > tick) tick = 32'(arr_tab[best]);
      wait_t              = tick - arr_tab[best];
      res.job_index       = best[JOB_IDX_W-1:0];
      res.start_time      = sat_time(tick);
      res.waiting_time    = sat_time(wait_t);
      res.turnaround_time = sat_time(wait_t + bur_tab[best]);
      res.last_result     = (k == n - 1);
      tick                = 32'(sat_time(tick + bur_tab[best]));
      done_f[best]        = 1'b1;
      run_order_q.insert(run_order_q.size(), res);
    end
    loaded_cnt = 0;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t exp;
    if (run_order_q.size() == 0) begin
      $error("unexpected result transaction: job_index %0d", got.job_index);
      err_cnt++;
    end else begin
      exp = run_order_q.pop_front();
      if (got.job_index !== exp.job_index) begin
        $error("job_index: expected %0d, actual %0d", exp.job_index, got.job_index);
        err_cnt++;
      end
      if (got.start_time !== exp.start_time) begin
        $error("start_time: expected %0d, actual %0d", exp.start_time, got.start_time);
        err_cnt++;
      end
      if (got.waiting_time !== exp.waiting_time) begin
        $error("waiting_time: expected %0d, actual %0d", exp.waiting_time, got.waiting_time);
        err_cnt++;
      end
      if (got.turnaround_time !== exp.turnaround_time) begin
        $error("turnaround_time: expected %0d, actual %0d",
               exp.turnaround_time, got.turnaround_time);
        err_cnt++;
      end
      if (got.last_result !== exp.last_result) begin
        $error("last_result: expected %0d, actual %0d", exp.last_result, got.last_result);
        err_cnt++;
      end
    end
  endtask

  // Driver: offer the head of the feed queue, hold it until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        schedule_job(in_data);
        void'(job_feed_q.pop_front());
      end
      if (!in_push || !in_full) begin
        if (job_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_push <= 1'b1;
          in_data <= job_feed_q[0];
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) check_result(out_data);
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_job(input int unsigned arr, input int unsigned bur, input bit last);
    in_item_t it;
    it.arrival_time = arr[ARR_W-1:0];
    it.burst_time   = bur[BUR_W-1:0];
    it.last_job     = last;
    job_feed_q.insert(job_feed_q.size(), it);
  endtask

  task automatic add_set(input int n, input mix_t mix);
    int unsigned base;
    int unsigned arr;
    int unsigned bur;
    base = $urandom_range(65535);
    for (int k = 0; k < n; k++) begin
      case (mix)
        MIX_CLUSTER: begin
          arr = $urandom_range(40);
          bur = $urandom_range(20);
        end
        MIX_WIDE: begin
          arr = $urandom;
          bur = $urandom;
        end
        MIX_SPREAD: begin
          arr  = base;
          base = base + $urandom_range(400);
          bur  = $urandom_range(300);
        end
        default: begin
          arr = $urandom_range(1) ? 32'hFFFF : $urandom_range(1);
          case ($urandom_range(3))
            0:       bur = 0;
            1:       bur = 1;
            2:       bur = 32'hFFFE;
            default: bur = 32'hFFFF;
          endcase
        end
      endcase
      push_job(arr, bur, k == n - 1);
    end
  endtask

  task automatic write_policy(input logic v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    policy_sh  = v;
  endtask

  task automatic wait_drain();
    do @(posedge clk); while (job_feed_q.size() != 0 || run_order_q.size() != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic run_phase(input logic pol, input int idle, input int stall,
                           input int n_items, input int big);
    int   cnt;
    int   n;
    mix_t mix;
    write_policy(pol);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    cnt            = 0;
    if (big != 0) begin
      add_set(big, MIX_CLUSTER);
      cnt = big;
    end
    while (cnt < n_items) begin
      n   = ($urandom_range(11) == 0) ? $urandom_range(20, 36) : $urandom_range(1, 6);
      mix = mix_t'($urandom_range(3));
      add_set(n, mix);
      cnt += n;
    end
    wait_drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    write_policy(POL_FCFS);

    // FCFS: lone zero burst, extremes, full ties, idle gap, bit toggles
    push_job(0, 0, 1);
    push_job('hFFFF, 'hFFFF, 0);
    push_job(0, 'hFFFF, 0);
    push_job(0, 1, 0);
    push_job(5, 1, 0);
    push_job(5, 1, 0);
    push_job(200000, 0, 1);
    push_job('hAAAA, 'h5555, 0);
    push_job('h5555, 'hAAAA, 1);
    wait_drain();

    // SJF: arrival rule at equality, ties, nothing arrived at time zero
    write_policy(POL_SJF);
    push_job(10, 5, 0);
    push_job(0, 20, 0);
    push_job(3, 1, 0);
    push_job(3, 1, 0);
    push_job(30, 2, 0);
    push_job(1000, 7, 1);
    push_job('hFFFF, 0, 0);
    push_job('hFFFF, 'hFFFF, 0);
    push_job('hFFF0, 3, 1);
    push_job(0, 5, 0);
    push_job(5, 10, 0);
    push_job(6, 1, 1);
    wait_drain();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0:       run_phase(1'((p + p / 4) % 2), 0, 0, 14, 0);
        1:       run_phase(1'((p + p / 4) % 2), 87, 0, 14, (p == 1) ? 34 : 0);
        2:       run_phase(1'((p + p / 4) % 2), 0, 87, 14, (p == 6) ? 32 : 0);
        default: run_phase(1'((p + p / 4) % 2), 13, 13, 14, 0);
      endcase
    end

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
